@@ rtl/swfs_pkg.sv @@
// Shared types and constants for the sliding-window frame statistics block.
package swfs_pkg;

   // Width of one frame-time sample and of every result field.
   localparam int SAMPLE_W = 24;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Status of the window store toward the sequencer.
   typedef struct packed {
      logic       busy;    // transaction in the store or min/max scan running
      sample_type old_us;  // evicted sample, valid in the cycle after a load
      sample_type min_us;  // window minimum after the scan
      sample_type max_us;  // window maximum after the scan
   } win_stat_type;

endpackage

@@ rtl/swfs_req_if.sv @@
// Request channel interface: one frame-time sample per transaction.
interface swfs_req_if;
   logic                 valid;
   logic                 ready;
   swfs_pkg::sample_type sample_us;

   modport source (output valid, output sample_us, input ready);
   modport sink (input valid, input sample_us, output ready);
endinterface

@@ rtl/swfs_rsp_if.sv @@
// Response channel interface: window mean, minimum, maximum and deviation.
interface swfs_rsp_if;
   logic                 valid;
   logic                 ready;
   swfs_pkg::sample_type mean_us;
   swfs_pkg::sample_type min_us;
   swfs_pkg::sample_type max_us;
   swfs_pkg::sample_type std_dev_us;

   modport source (output valid, output mean_us, output min_us, output max_us,
                   output std_dev_us, input ready);
   modport sink (input valid, input mean_us, input min_us, input max_us,
                 input std_dev_us, output ready);
endinterface

@@ rtl/swfs_window.sv @@
// Circular sample store with write pointer, valid bits and min/max scan.
module swfs_window #(
   parameter int WINDOW_LENGTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_i,
   input  swfs_pkg::sample_type   wr_data_i,
   output swfs_pkg::win_stat_type stat_o
);

   localparam int IDX_W = $clog2(WINDOW_LENGTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

   swfs_pkg::sample_type win_mem [WINDOW_LENGTH];

   logic [WINDOW_LENGTH-1:0] vld_ff, vld_in;
   logic [IDX_W-1:0]         wptr_ff, wptr_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [IDX_W-1:0]         rd_addr;
   logic                     write_ff, write_in;
   logic                     issue_ff, issue_in;
   logic                     cmp_ff, cmp_in;
   logic                     last_ff, last_in;
   logic                     busy_ff, busy_in;
   logic                     rd_vld_ff;
   swfs_pkg::sample_type     rd_data_ff;
   swfs_pkg::sample_type     rd_val;
   swfs_pkg::sample_type     min_ff, min_in;
   swfs_pkg::sample_type     max_ff, max_in;

   always_comb begin
      rd_addr  = issue_ff ? scan_ff : wptr_ff;
      // never-written entries read as the reset value
      rd_val   = rd_vld_ff ? rd_data_ff : '0;
      write_in = load_i;
      vld_in   = vld_ff;
      wptr_in  = wptr_ff;
      issue_in = issue_ff;
      scan_in  = scan_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      busy_in  = busy_ff;
      cmp_in   = issue_ff;
      last_in  = issue_ff && (scan_ff == LAST_IDX);

      if (load_i) begin
         busy_in = 1'b1;
      end
      // store the new sample, advance the pointer, start the scan
      if (write_ff) begin
         vld_in[wptr_ff] = 1'b1;
         wptr_in         = (wptr_ff == LAST_IDX) ? '0 : wptr_ff + 1'b1;
         issue_in        = 1'b1;
         scan_in         = '0;
         min_in          = '1;
         max_in          = '0;
      end
      if (issue_ff) begin
         if (scan_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            scan_in = scan_ff + 1'b1;
         end
      end
      if (cmp_ff) begin
         if (rd_val < min_ff) begin
            min_in = rd_val;
         end
         if (rd_val > max_ff) begin
            max_in = rd_val;
         end
         if (last_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_ff) begin
         win_mem[wptr_ff] <= wr_data_i;
      end
      rd_data_ff <= win_mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
      min_ff     <= min_in;
      max_ff     <= max_in;
      scan_ff    <= scan_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         wptr_ff  <= '0;
         write_ff <= 1'b0;
         issue_ff <= 1'b0;
         cmp_ff   <= 1'b0;
         last_ff  <= 1'b0;
         busy_ff  <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         wptr_ff  <= wptr_in;
         write_ff <= write_in;
         issue_ff <= issue_in;
         cmp_ff   <= cmp_in;
         last_ff  <= last_in;
         busy_ff  <= busy_in;
      end
   end

   assign stat_o.busy   = busy_ff;
   assign stat_o.old_us = rd_val;
   assign stat_o.min_us = min_ff;
   assign stat_o.max_us = max_ff;

endmodule

@@ rtl/swfs_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
module swfs_isqrt #(
   parameter int RAD_W = 58
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_i,
   input  logic [RAD_W-1:0]   rad_i,
   output logic               busy_o,
   output logic [RAD_W/2-1:0] root_o
);

   localparam logic [RAD_W-1:0] TOP_BIT = RAD_W'(1) << (RAD_W - 2);

   logic [RAD_W-1:0] x_ff, x_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W-1:0] trial;
   logic             busy_ff, busy_in;

   always_comb begin
      trial   = root_ff + bit_ff;
      x_in    = x_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start_i) begin
         x_in    = rad_i;
         root_in = '0;
         bit_in  = TOP_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in    = x_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         // the step with the lowest bit finishes the root
         if (bit_ff[0]) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy_o = busy_ff;
   assign root_o = root_ff[RAD_W/2-1:0];

endmodule

@@ rtl/swfs_cdiv.sv @@
// Division by the constant window length through a reciprocal multiply in two halves.
module swfs_cdiv #(
   parameter int DIVD_W  = 29,
   parameter int DIVISOR = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_i,
   input  logic [DIVD_W-1:0]    dvd_i,
   output logic                 busy_o,
   output swfs_pkg::sample_type quo_o
);

   localparam int Q_W    = swfs_pkg::SAMPLE_W;
   localparam int LOG_D  = $clog2(DIVISOR);
   // floor(x * RCP / 2^SHIFT) equals floor(x / DIVISOR) for every x below 2^DIVD_W
   localparam int SHIFT  = DIVD_W + LOG_D;
   localparam int RCP_W  = DIVD_W + 2;
   localparam int HALF_W = (RCP_W + 1) / 2;
   localparam int PART_W = DIVD_W + HALF_W;
   localparam int ACC_W  = DIVD_W + 2 * HALF_W;
   localparam logic [63:0] RCP =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [HALF_W-1:0] RCP_LO = HALF_W'(RCP);
   localparam logic [HALF_W-1:0] RCP_HI = HALF_W'(RCP >> HALF_W);

   logic [DIVD_W-1:0] dvd_ff, dvd_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              high_ff, high_in;
   logic              busy_ff, busy_in;
   logic [HALF_W-1:0] rcp_part;
   logic [PART_W-1:0] part;

   always_comb begin
      // one multiplier, low half of the reciprocal first, then the high half
      rcp_part = high_ff ? RCP_HI : RCP_LO;
      part     = dvd_ff * rcp_part;
      dvd_in   = dvd_ff;
      acc_in   = acc_ff;
      high_in  = high_ff;
      busy_in  = busy_ff;
      if (start_i) begin
         dvd_in  = dvd_i;
         high_in = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (high_ff) begin
            acc_in  = acc_ff + (ACC_W'(part) << HALF_W);
            busy_in = 1'b0;
         end else begin
            acc_in  = ACC_W'(part);
            high_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      acc_ff  <= acc_in;
      high_ff <= high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy_o = busy_ff;
   assign quo_o  = acc_ff[SHIFT +: Q_W];

endmodule

@@ rtl/sliding_window_frame_stats.sv @@
// Top level of the sliding-window frame statistics block.
//
// Each request transaction carries one frame time in microseconds. The block
// replaces the oldest of the last WINDOW_LENGTH samples with it and returns
// one response transaction with the window's floor mean, minimum, maximum and
// floor population standard deviation. After reset the window holds zeros,
// which take part in every statistic until real samples displace them; valid
// bits give this at once, with no clearing pass. Running sum and sum of
// squares are kept exact. From acceptance to a registered response a sample
// passes the update states UPD to SPR, with the squares on the shared multiplier,
// 24 + log2(WINDOW_LENGTH) steps of the square-root unit at one root bit per
// cycle, then the handoff around the reciprocal divider by the window length.
// For windows longer than 36 the min/max scan of the store, one entry per
// cycle, sets the time instead. The request side is not ready while a sample
// is at work and opens in the same cycle as the response becomes valid; a
// finished response waits in its output register while the next sample is
// accepted.
module sliding_window_frame_stats #(
   parameter int WINDOW_LENGTH = 32
) (
   input logic        clock,
   input logic        reset,
   swfs_req_if.sink   req_chan,
   swfs_rsp_if.source rsp_chan
);

   localparam int LOG_N = $clog2(WINDOW_LENGTH);
   localparam int SUM_W = swfs_pkg::SAMPLE_W + LOG_N;
   localparam int SQ_W  = 2 * swfs_pkg::SAMPLE_W + LOG_N;
   localparam int SPR_W = 2 * SUM_W;
   localparam logic [SPR_W-1:0] N_WIDE = SPR_W'(WINDOW_LENGTH);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_UPD  = 9'b000000010,
      ST_SQA  = 9'b000000100,
      ST_SQB  = 9'b000001000,
      ST_NSQ  = 9'b000010000,
      ST_SPR  = 9'b000100000,
      ST_ROOT = 9'b001000000,
      ST_SDIV = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   swfs_pkg::win_stat_type win_stat;
   swfs_pkg::sample_type   sample_ff, sample_in;
   swfs_pkg::sample_type   old_ff, old_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sumsq_ff, sumsq_in;
   logic [SPR_W-1:0]       prod_ff, prod_in;
   logic [SPR_W-1:0]       nsq_ff, nsq_in;
   logic [SUM_W-1:0]       mul_a, mul_b;
   swfs_pkg::sample_type   mean_ff, mean_in;
   swfs_pkg::sample_type   std_ff, std_in;
   logic                   accept;
   logic                   sqrt_start, sqrt_busy;
   logic [SUM_W-1:0]       sqrt_root;
   logic                   div_start, div_busy;
   logic [SUM_W-1:0]       div_dvd;
   swfs_pkg::sample_type   div_quo;
   logic                   rsp_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   swfs_pkg::sample_type   rsp_mean_ff, rsp_min_ff, rsp_max_ff, rsp_std_ff;

   swfs_window #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .load_i    (accept),
      .wr_data_i (sample_ff),
      .stat_o    (win_stat)
   );

   swfs_isqrt #(.RAD_W(SPR_W)) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start_i (sqrt_start),
      .rad_i   (nsq_ff - prod_ff),
      .busy_o  (sqrt_busy),
      .root_o  (sqrt_root)
   );

   swfs_cdiv #(.DIVD_W(SUM_W), .DIVISOR(WINDOW_LENGTH)) u_cdiv (
      .clock   (clock),
      .reset   (reset),
      .start_i (div_start),
      .dvd_i   (div_dvd),
      .busy_o  (div_busy),
      .quo_o   (div_quo)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // shared multiplier: sample squared, evicted sample squared, sum squared
   always_comb begin
      case (state_ff)
         ST_UPD: begin
            mul_a = SUM_W'(sample_ff);
            mul_b = SUM_W'(sample_ff);
         end
         ST_SQA: begin
            mul_a = SUM_W'(old_ff);
            mul_b = SUM_W'(old_ff);
         end
         ST_SQB: begin
            mul_a = sum_ff;
            mul_b = sum_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      old_in    = old_ff;
      sum_in    = sum_ff;
      sumsq_in  = sumsq_ff;
      nsq_in    = nsq_ff;
      mean_in   = mean_ff;
      std_in    = std_ff;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_dvd    = sum_ff;
      rsp_load   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_chan.sample_us;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            // evicted sample arrives from the store this cycle
            old_in   = win_stat.old_us;
            sum_in   = sum_ff - SUM_W'(win_stat.old_us) + SUM_W'(sample_ff);
            state_in = ST_SQA;
         end
         ST_SQA: begin
            sumsq_in = sumsq_ff + SQ_W'(prod_ff);
            state_in = ST_SQB;
         end
         ST_SQB: begin
            sumsq_in  = sumsq_ff - SQ_W'(prod_ff);
            div_start = 1'b1;
            state_in  = ST_NSQ;
         end
         ST_NSQ: begin
            nsq_in   = SPR_W'(sumsq_ff) * N_WIDE;
            state_in = ST_SPR;
         end
         ST_SPR: begin
            // spread = N * sumsq - sum^2 goes straight into the root unit
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sqrt_busy && !div_busy) begin
               mean_in   = div_quo;
               div_dvd   = sqrt_root;
               div_start = 1'b1;
               state_in  = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (!div_busy && !win_stat.busy) begin
               std_in   = div_quo;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      old_ff    <= old_in;
      nsq_ff    <= nsq_in;
      mean_ff   <= mean_in;
      std_ff    <= std_in;
      if (state_ff == ST_UPD || state_ff == ST_SQA || state_ff == ST_SQB) begin
         prod_ff <= prod_in;
      end
      if (rsp_load) begin
         rsp_mean_ff <= mean_ff;
         rsp_min_ff  <= win_stat.min_us;
         rsp_max_ff  <= win_stat.max_us;
         rsp_std_ff  <= std_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mean_us    = rsp_mean_ff;
   assign rsp_chan.min_us     = rsp_min_ff;
   assign rsp_chan.max_us     = rsp_max_ff;
   assign rsp_chan.std_dev_us = rsp_std_ff;

   a_sqrt_start_idle: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_busy)
      else $error("square root restarted while busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_scan_done_at_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !win_stat.busy)
      else $error("response formed before the window scan finished");

   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (win_stat.min_us <= mean_ff && mean_ff <= win_stat.max_us))
      else $error("mean outside the window minimum and maximum");

endmodule
